// ----- hdl/rsas_pkg.sv -----
// shared types and constants of the rotated sorted array search unit
// no dependencies; imported by rsas_ctrl, rsas_datapath and the top level

package rsas_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 32;
    localparam int POS_W           = 10;
    localparam int CMD_W           = 2;
    localparam int S_TDATA_W       = 2 * VALUE_W;
    localparam int M_TDATA_W       = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transaction accepted this cycle
        logic rd1;       // issue midpoint and low reads
        logic rd2;       // midpoint and low data back, issue high read
        logic eval;      // high data back, right-half decision
        logic load_out;  // copy search result into output register
    } rsas_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;   // store is empty
        logic hit;          // midpoint equals key
        logic left_sorted;  // low value <= midpoint value
        logic next_empty;   // range empty after this step's update
    } rsas_stat_t;

endpackage

// ----- hdl/rsas_ram.sv -----
// generic ram: one write port, two read ports with registered read data
// no dependencies

module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hdl/rsas_datapath.sv -----
// datapath: element store, count, search bounds, comparators and result register
// depends on rsas_pkg and rsas_ram

module rsas_datapath #(
    parameter int STORE_DEPTH = rsas_pkg::STORE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsas_pkg::rsas_cmd_t           cmd,
    output rsas_pkg::rsas_stat_t          stat,
    input  logic [rsas_pkg::CMD_W-1:0]    in_command,
    input  logic [rsas_pkg::VALUE_W-1:0]  in_element_value,
    input  logic [rsas_pkg::VALUE_W-1:0]  in_search_key,
    output logic                          out_found,
    output logic [rsas_pkg::POS_W-1:0]    out_position
);
    import rsas_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             lo_reg, lo_next;
    logic [CW-1:0]             hx_reg, hx_next;     // high bound plus one
    logic [AW-1:0]             mid_reg;
    logic signed [VALUE_W-1:0] key_reg, vm_reg;
    logic                      found_reg, found_next;
    logic [AW-1:0]             idx_reg;
    logic                      out_found_reg;
    logic [POS_W-1:0]          out_pos_reg;

    logic                      ram_we;
    logic [AW-1:0]             raddr_b;
    logic [VALUE_W-1:0]        rdata_a, rdata_b;
    logic signed [VALUE_W-1:0] vm_c, vl_c, vh_c;
    logic [CW:0]               mid_sum;
    logic [CW-1:0]             mid_half;
    logic [AW-1:0]             mid_c;
    logic [CW-1:0]             mid_plus1;
    logic [CW-1:0]             hx_minus1;
    logic                      go_left_l, go_left_r, go_left;
    logic [CW-1:0]             step_lo, step_hx;
    logic [AW+POS_W-1:0]       idx_ext;

    assign ram_we = cmd.take && (in_command == CMD_APPEND) &&
                    (count_reg < CW'(STORE_DEPTH));

    rsas_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (count_reg[AW-1:0]),
        .wdata   (in_element_value),
        .raddr_a (mid_c),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // midpoint of [lo, hx-1]
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hx_reg} - (CW+1)'(1);
    assign mid_half  = mid_sum[CW:1];
    assign mid_c     = mid_half[AW-1:0];
    assign hx_minus1 = hx_reg - CW'(1);
    assign raddr_b   = cmd.rd2 ? hx_minus1[AW-1:0] : lo_reg[AW-1:0];

    assign vm_c = rdata_a;
    assign vl_c = rdata_b;
    assign vh_c = rdata_b;

    // left half sorted: keep it when key lies in [vl, vm)
    assign go_left_l = (vl_c <= key_reg) && (key_reg < vm_c);
    // right half sorted: keep it when key lies in (vm, vh]
    assign go_left_r = !((vm_reg < key_reg) && (key_reg <= vh_c));
    assign go_left   = cmd.eval ? go_left_r : go_left_l;

    assign mid_plus1 = CW'(mid_reg) + CW'(1);
    assign step_lo   = go_left ? lo_reg : mid_plus1;
    assign step_hx   = go_left ? CW'(mid_reg) : hx_reg;

    assign stat.count_zero  = (count_reg == '0);
    assign stat.hit         = (vm_c == key_reg);
    assign stat.left_sorted = (vl_c <= vm_c);
    assign stat.next_empty  = (step_lo >= step_hx);

    always_comb begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hx_next    = hx_reg;
        found_next = found_reg;
        if (cmd.take) begin
            case (in_command)
                CMD_CLEAR: begin
                    count_next = '0;
                end
                CMD_APPEND: begin
                    if (ram_we) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_SEARCH: begin
                    lo_next    = '0;
                    hx_next    = count_reg;
                    found_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.rd2) begin
            if (stat.hit) begin
                found_next = 1'b1;
            end else if (stat.left_sorted) begin
                lo_next = step_lo;
                hx_next = step_hx;
            end
        end
        if (cmd.eval) begin
            lo_next = step_lo;
            hx_next = step_hx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hx_reg    <= hx_next;
        found_reg <= found_next;
        if (cmd.take) begin
            key_reg <= in_search_key;
        end
        if (cmd.rd1) begin
            mid_reg <= mid_c;
        end
        if (cmd.rd2) begin
            vm_reg <= vm_c;
            if (stat.hit) begin
                idx_reg <= mid_reg;
            end
        end
        if (cmd.load_out) begin
            out_found_reg <= found_reg;
            out_pos_reg   <= found_reg ? idx_ext[POS_W-1:0] : '0;
        end
    end

    assign idx_ext      = (AW+POS_W)'(idx_reg);
    assign out_found    = out_found_reg;
    assign out_position = out_pos_reg;

endmodule

// ----- hdl/rsas_ctrl.sv -----
// controller: sequences the halving steps and owns both handshakes
// depends on rsas_pkg

module rsas_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rsas_pkg::CMD_W-1:0] in_command,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rsas_pkg::rsas_cmd_t        cmd,
    input  rsas_pkg::rsas_stat_t       stat
);
    import rsas_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD1    = 5'b00010,
        S_RD2    = 5'b00100,
        S_EVAL   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.take       = take;
        case (state_reg)
            S_IDLE: begin
                if (take && in_command == CMD_SEARCH) begin
                    state_next = stat.count_zero ? S_RESULT : S_RD1;
                end
            end
            S_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2: begin
                cmd.rd2 = 1'b1;
                if (stat.hit) begin
                    state_next = S_RESULT;
                end else if (stat.left_sorted) begin
                    state_next = stat.next_empty ? S_RESULT : S_RD1;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = stat.next_empty ? S_RESULT : S_RD1;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/rotated_sorted_array_search_unit.sv -----
// top level of the rotated sorted array search unit
// depends on rsas_pkg, rsas_ctrl, rsas_datapath (which holds rsas_ram)
//
// usage
//   input stream s_axis: s_axis_tuser carries the command (clear, append, search),
//   s_axis_tdata carries the element value (bits 31:0) and search key (bits 63:32)
//   clear and append finish in the cycle they are accepted and give no result
//   appends past STORE_DEPTH entries are dropped, the count saturates
//   each search gives one result transaction on m_axis: m_axis_tuser is the found
//   flag, m_axis_tdata[9:0] the index (zero when not found)
//   a search runs halving steps: each reads the midpoint and low entries on the
//   two store read ports, plus the high entry when the right half must be
//   checked; at most log2(count)+1 steps (11 at 1024 entries), then the result
//   register is loaded; an empty store skips the steps and answers not found
//   one item at a time: s_axis_tready is high only while the controller is idle
//   the result sits in an output register, so a new item is taken while a result
//   waits; a finished search stalls before its result until m_axis_tready frees it
//   reset (aresetn low, synchronous) empties the store and drops any pending result;
//   the store contents themselves are not cleared and need no clearing pass

module rotated_sorted_array_search_unit #(
    parameter int STORE_DEPTH = rsas_pkg::STORE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rsas_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // element_value, search_key
    input  logic [rsas_pkg::CMD_W-1:0]      s_axis_tuser,  // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rsas_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // position, zero pad
    output logic                            m_axis_tuser   // found
);
    import rsas_pkg::*;

    rsas_cmd_t        cmd;
    rsas_stat_t       stat;
    logic [POS_W-1:0] position;

    // control: state machine and handshakes
    rsas_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // store, bounds, compare logic and output register
    rsas_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_command       (s_axis_tuser),
        .in_element_value (s_axis_tdata[VALUE_W-1:0]),
        .in_search_key    (s_axis_tdata[2*VALUE_W-1:VALUE_W]),
        .out_found        (m_axis_tuser),
        .out_position     (position)
    );

    // pad the index out to whole bytes
    assign m_axis_tdata = M_TDATA_W'(position);

endmodule

// ----- tb/rotated_sorted_array_search_unit_test.sv -----
// self-checking testbench for rotated_sorted_array_search_unit
// drives clear, append and search transactions and checks every search answer against
// a behavioral copy of the rotated binary search; depends on rsas_pkg and the unit itself

module rotated_sorted_array_search_unit_test;
    import rsas_pkg::*;

    localparam int STORE_DEPTH  = STORE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 19;         // chance per cycle that a side holds back
    localparam int QUIET_FROM   = 2000;       // cycle window with no idling on either side
    localparam int QUIET_TO     = 9000;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 60;         // longer than the slowest search

    // command code 3 has no meaning in the unit
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] element;
        logic signed [VALUE_W-1:0] key;
        bit                        hold_until_drained;  // pause marker, not a transaction
    } feed_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // element_value, search_key
    logic [CMD_W-1:0]       s_axis_tuser  = '0;  // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // position, zero pad
    logic                   m_axis_tuser;        // found

    rotated_sorted_array_search_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // pending input transactions and the answers still owed by the unit
    feed_item_t command_feed[$];
    lookup_t    lookup_answers[$];

    // shadow copy of the unit's state
    logic signed [VALUE_W-1:0] shadow_store[STORE_DEPTH];
    int                        shadow_count = 0;

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  stimulus_items = 0;
    bit  s_handshake    = 1'b0;   // input transaction taken at the last rising edge

    // tallies for the closing summary
    int  clears_seen, appends_kept, appends_dropped, unused_seen;
    int  searches_seen, hits_seen, answers_checked;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // rotated-array binary search: at each midpoint pick the sorted half and keep it
    // only when the key lies inside its bounds
    function automatic lookup_t rotated_lookup(input logic signed [VALUE_W-1:0] key);
        int                        lo, hi, mid;
        logic signed [VALUE_W-1:0] v_mid, v_lo, v_hi;
        lookup_t                   res;
        bit                        hit;
        res = '0;
        hit = 1'b0;
        lo  = 0;
        hi  = shadow_count - 1;
        while (lo <= hi && !hit) begin
            mid   = lo + (hi - lo) / 2;
            v_mid = shadow_store[mid];
            v_lo  = shadow_store[lo];
            v_hi  = shadow_store[hi];
            if (v_mid == key) begin
                hit          = 1'b1;
                res.found    = 1'b1;
                res.position = POS_W'(mid);
            end else if (v_lo <= v_mid) begin
                // left half sorted
                if (v_lo <= key && key < v_mid) hi = mid - 1;
                else                            lo = mid + 1;
            end else begin
                // right half sorted
                if (v_mid < key && key <= v_hi) lo = mid + 1;
                else                            hi = mid - 1;
            end
        end
        return res;
    endfunction

    task automatic feed_cmd(input logic [CMD_W-1:0] cmd,
                            input logic signed [VALUE_W-1:0] element,
                            input logic signed [VALUE_W-1:0] key);
        command_feed.push_back('{cmd, element, key, 1'b0});
        if (cmd != CMD_UNUSED) stimulus_items++;
    endtask

    // sender holds back until every owed answer has come
    task automatic feed_pause();
        command_feed.push_back('{CMD_CLEAR, '0, '0, 1'b1});
    endtask

    // one run: optional clear, n appends of a rotated ascending set, then probe searches;
    // a broken run corrupts values, may keep old contents, mixes in stray transactions;
    // spill appends go past the store depth and must be dropped
    task automatic queue_rotated_run(input int n, input int probes, input bit broken,
                                     input int spill);
        logic signed [VALUE_W-1:0] ascending[$];
        logic signed [VALUE_W-1:0] run_vals[$];
        logic signed [VALUE_W-1:0] v, key;
        longint                    acc, gap;
        int                        shift, pick;
        if ($urandom_range(0, 3) == 0) begin
            // dense set, so neighbors of stored values are often present too
            gap = 4;
            acc = longint'($urandom_range(0, 32'hFFFF_0000)) - 64'sd2147483648 - 1;
        end else begin
            gap = 64'sd4294967296 / (n + 1);
            acc = -64'sd2147483648 - 1;
        end
        for (int i = 0; i < n; i++) begin
            acc = acc + 1 + longint'($urandom_range(0, 32'(gap - 1)));
            ascending.push_back(acc[VALUE_W-1:0]);
        end
        shift = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (!broken || $urandom_range(0, 1)) feed_cmd(CMD_CLEAR, $urandom, $urandom);
        for (int i = 0; i < n; i++) begin
            v = ascending[(i + shift) % n];
            if (broken && $urandom_range(0, 3) == 0) begin
                if (run_vals.size() != 0 && $urandom_range(0, 1))
                    v = run_vals[$urandom_range(0, run_vals.size() - 1)];
                else
                    v = $urandom;
            end
            run_vals.push_back(v);
            feed_cmd(CMD_APPEND, v, $urandom);
            if (broken && $urandom_range(0, 9) == 0) feed_cmd(CMD_UNUSED, $urandom, $urandom);
            if (broken && $urandom_range(0, 9) == 0) feed_cmd(CMD_SEARCH, $urandom, v);
        end
        for (int i = 0; i < spill; i++) begin
            v = $urandom;
            feed_cmd(CMD_APPEND, v, $urandom);
            if (i == 0) feed_cmd(CMD_SEARCH, $urandom, v);
        end
        if (spill > 0 && n > 0) feed_cmd(CMD_SEARCH, $urandom, run_vals[n - 1]);
        for (int i = 0; i < probes; i++) begin
            pick = $urandom_range(0, 9);
            if (run_vals.size() == 0 || pick >= 8) begin
                key = $urandom;
            end else begin
                v = run_vals[$urandom_range(0, run_vals.size() - 1)];
                if (pick < 6)       key = v;
                else if (pick == 6) key = v + 1;
                else                key = v - 1;
            end
            feed_cmd(CMD_SEARCH, $urandom, key);
        end
    endtask

    // input driver: offers the next pending transaction at the falling edge and
    // holds it until the unit takes it; both sides idle at random outside the quiet window
    always @(negedge aclk) begin : feed_driver
        bit         quiet;
        feed_item_t nxt;
        quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_handshake) begin
            // offered transaction not taken yet, keep it on the bus
        end else if (command_feed.size() != 0 && command_feed[0].hold_until_drained) begin
            if (lookup_answers.size() == 0) nxt = command_feed.pop_front();
            s_axis_tvalid <= 1'b0;
        end else if (command_feed.size() != 0 &&
                     (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = command_feed.pop_front();
            s_axis_tuser  <= nxt.cmd;
            s_axis_tdata  <= {nxt.key, nxt.element};
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: checks each result transaction against the oldest owed answer, then
    // updates the shadow state with the input transaction taken at this edge
    always @(posedge aclk) begin : bus_monitor
        lookup_t                   want;
        logic signed [VALUE_W-1:0] element, key;
        cycle_count++;
        s_handshake = aresetn && s_axis_tvalid && s_axis_tready;

        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (lookup_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result found=%0b position=%0d", $time,
                         m_axis_tuser, m_axis_tdata[POS_W-1:0]);
            end else begin
                want = lookup_answers.pop_front();
                answers_checked++;
                if (m_axis_tuser !== want.found) begin
                    mismatch_count++;
                    $display("%0t: found mismatch, expected %0b actual %0b", $time,
                             want.found, m_axis_tuser);
                end
                if (m_axis_tdata[POS_W-1:0] !== want.position) begin
                    mismatch_count++;
                    $display("%0t: position mismatch, expected %0d actual %0d", $time,
                             want.position, m_axis_tdata[POS_W-1:0]);
                end
            end
        end

        if (s_handshake) begin
            element = s_axis_tdata[VALUE_W-1:0];
            key     = s_axis_tdata[2*VALUE_W-1:VALUE_W];
            case (s_axis_tuser)
                CMD_CLEAR: begin
                    shadow_count = 0;
                    clears_seen++;
                end
                CMD_APPEND: begin
                    // a full store drops the element, count saturates
                    if (shadow_count < STORE_DEPTH) begin
                        shadow_store[shadow_count] = element;
                        shadow_count++;
                        appends_kept++;
                    end else begin
                        appends_dropped++;
                    end
                end
                CMD_SEARCH: begin
                    want = rotated_lookup(key);
                    lookup_answers.push_back(want);
                    searches_seen++;
                    if (want.found) hits_seen++;
                end
                default: unused_seen++;
            endcase
        end
    end

    initial begin : stimulus
        int n, roll, full_before;
        aresetn = 1'b0;

        // directed: empty store, unused command, extremes in a rotated set, clear
        feed_cmd(CMD_SEARCH, $urandom, 32'sd0);
        feed_cmd(CMD_UNUSED, 32'sd42, 32'sd42);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd42);
        feed_cmd(CMD_APPEND, 32'sd5, $urandom);
        feed_cmd(CMD_APPEND, 32'sd100, $urandom);
        feed_cmd(CMD_APPEND, 32'sh7FFF_FFFF, $urandom);
        feed_cmd(CMD_APPEND, 32'sh8000_0000, $urandom);
        feed_cmd(CMD_APPEND, -32'sd7, $urandom);
        feed_cmd(CMD_APPEND, 32'sd0, $urandom);
        feed_cmd(CMD_APPEND, 32'sd3, $urandom);
        feed_cmd(CMD_SEARCH, $urandom, 32'sh7FFF_FFFF);
        feed_cmd(CMD_SEARCH, $urandom, 32'sh8000_0000);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd5);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd3);
        feed_cmd(CMD_SEARCH, $urandom, -32'sd7);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd4);
        feed_cmd(CMD_SEARCH, $urandom, -32'sd1);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd100);
        feed_cmd(CMD_CLEAR, $urandom, $urandom);
        feed_cmd(CMD_SEARCH, $urandom, 32'sd5);
        feed_pause();

        // random runs, mostly well-formed rotated sets, with one full-store fill early on
        full_before = -1;
        while (stimulus_items < RANDOM_ITEMS) begin
            if (full_before < 0 && stimulus_items > RANDOM_ITEMS / 32) begin
                full_before = stimulus_items;
                feed_pause();
                queue_rotated_run(STORE_DEPTH, 14, 1'b0, 3);
                feed_pause();
            end
            roll = $urandom_range(0, 99);
            if (roll < 70)      n = $urandom_range(0, 16);
            else if (roll < 95) n = $urandom_range(17, 64);
            else                n = $urandom_range(65, 300);
            if ($urandom_range(0, 99) < 8) feed_pause();
            queue_rotated_run(n, $urandom_range(1, 8), $urandom_range(0, 99) < 15, 0);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(command_feed.size() == 0 && !s_axis_tvalid && lookup_answers.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        if (cycle_count < CYCLE_LIMIT) repeat (SETTLE) @(posedge aclk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d answers still owed", $time,
                     cycle_count, lookup_answers.size());
            $display("[FAIL] regression broken");
        end else begin
            if (lookup_answers.size() != 0) begin
                mismatch_count += lookup_answers.size();
                $display("%0t: %0d answers never arrived", $time, lookup_answers.size());
            end
            $display("run covered %0d clears, %0d appends kept, %0d dropped, %0d unused",
                     clears_seen, appends_kept, appends_dropped, unused_seen);
            $display("%0d searches (%0d hits), %0d results checked, %0d mismatches",
                     searches_seen, hits_seen, answers_checked, mismatch_count);
            if (mismatch_count == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rsas_pkg.sv
hdl/rsas_ram.sv
hdl/rsas_datapath.sv
hdl/rsas_ctrl.sv
hdl/rotated_sorted_array_search_unit.sv
tb/rotated_sorted_array_search_unit_test.sv
